// ===== hw/rtl/bah_pkg.sv =====
// Shared types, register indexes and constants of the breath-aware heater PID unit.
`timescale 1ns / 1ps
`default_nettype none
package bah_pkg;

    localparam int CHECK_INTERVAL_DEF = 10;
    localparam int CNT_W              = 4;
    localparam int TEMP_W             = 16;
    localparam int GAIN_W             = 16;
    localparam int DUTY_W             = 10;
    localparam int ERR_W              = 17;
    localparam int INTEG_W            = 17;
    localparam int IINC_W             = 21;
    localparam int PMAG_W             = 32;
    localparam int PTERM_W            = 35;
    localparam int DPROD_W            = 35;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;

    localparam logic [15:0] SENSOR_LOW   = 16'd1600;
    localparam logic [15:0] SENSOR_HIGH  = 16'd64800;
    localparam logic [15:0] BAND_LIMIT   = 16'd384;
    localparam logic [10:0] DUTY_MAX     = 11'd1000;
    localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT  = 35;

    typedef enum logic [1:0] {
        PH_PAUSE  = 2'd0,
        PH_INHALE = 2'd1,
        PH_EXHALE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_SENSOR   = 2'd1,
        FAULT_OVERTEMP = 2'd2
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_SETPOINT     = 3'd3,
        REG_FEEDFORWARD  = 3'd4,
        REG_OVERTEMP     = 3'd5,
        REG_SLOPE_THRESH = 3'd6,
        REG_PID_CEILING  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [TEMP_W-1:0] setpoint;
        logic [DUTY_W-1:0] feedforward_duty;
        logic [TEMP_W-1:0] overtemp_limit;
        logic [TEMP_W-1:0] slope_threshold;
        logic [DUTY_W-1:0] pid_ceiling;
    } cfg_t;

    // Front stage result: fault decision, phase and the three gain products.
    typedef struct packed {
        logic                       vld;
        fault_t                     fault;
        phase_t                     phase;
        logic                       run_pid;
        logic                       in_band;
        logic                       e_neg;
        logic [PMAG_W-1:0]          p_mag;
        logic [IINC_W-1:0]          i_inc;
        logic signed [DPROD_W-1:0]  d_prod;
    } s1_t;

    // Integral stage result: signed P term, updated integral and D term.
    typedef struct packed {
        logic                       vld;
        fault_t                     fault;
        phase_t                     phase;
        logic                       run_pid;
        logic signed [PTERM_W-1:0]  p_term;
        logic [INTEG_W-1:0]         integ;
        logic signed [DPROD_W-1:0]  d_prod;
    } s2_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bah_cfg_regs.sv =====
// Configuration register file of the heater PID unit.
`timescale 1ns / 1ps
`default_nettype none
module bah_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bah_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bah_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bah_pkg::cfg_t                         cfg
);
    import bah_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_PROP_GAIN:    cfg_next.prop_gain        = cfg_wdata;
                REG_INTEG_GAIN:   cfg_next.integ_gain       = cfg_wdata;
                REG_DERIV_GAIN:   cfg_next.deriv_gain       = cfg_wdata;
                REG_SETPOINT:     cfg_next.setpoint         = cfg_wdata;
                REG_FEEDFORWARD:  cfg_next.feedforward_duty = cfg_wdata[DUTY_W-1:0];
                REG_OVERTEMP:     cfg_next.overtemp_limit   = cfg_wdata;
                REG_SLOPE_THRESH: cfg_next.slope_threshold  = cfg_wdata;
                REG_PID_CEILING:  cfg_next.pid_ceiling      = cfg_wdata[DUTY_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain        <= 16'd6400;
            cfg_reg.integ_gain       <= 16'd80;
            cfg_reg.deriv_gain       <= 16'd12800;
            cfg_reg.setpoint         <= 16'd8448;
            cfg_reg.feedforward_duty <= 10'd400;
            cfg_reg.overtemp_limit   <= 16'd10240;
            cfg_reg.slope_threshold  <= 16'd26;
            cfg_reg.pid_ceiling      <= 10'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bah_front.sv =====
// Front stage: fault checks, breath phase tracking, error and gain products.
`timescale 1ns / 1ps
`default_nettype none
module bah_front #(
    parameter int CHECK_INTERVAL = bah_pkg::CHECK_INTERVAL_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_vld,
    input  wire logic [bah_pkg::TEMP_W-1:0]    in_temp,
    input  wire logic [bah_pkg::TEMP_W-1:0]    in_level,
    input  wire bah_pkg::cfg_t                 cfg,
    output bah_pkg::s1_t                       s1
);
    import bah_pkg::*;

    localparam logic [CNT_W-1:0] INTERVAL = CNT_W'(CHECK_INTERVAL);

    phase_t                   phase_reg, phase_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [TEMP_W-1:0]        prev_temp_reg, prev_temp_next;
    logic signed [ERR_W-1:0]  prev_err_reg, prev_err_next;
    s1_t                      s1_reg, s1_next;

    logic                     ok;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     check_hit;
    logic signed [17:0]       change;
    logic signed [17:0]       thr;
    phase_t                   new_phase;
    phase_t                   phase_eff;
    logic signed [ERR_W-1:0]  err;
    logic signed [17:0]       err_diff;
    logic [15:0]              abs_err;
    logic [24:0]              i_prod;

    always_comb begin
        s1_next        = s1_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        prev_temp_next = prev_temp_reg;
        prev_err_next  = prev_err_reg;

        ok = 1'b0;
        s1_next.fault = FAULT_NONE;
        if ((in_level < SENSOR_LOW) || (in_level > SENSOR_HIGH)) begin
            s1_next.fault = FAULT_SENSOR;
        end else if (in_temp > cfg.overtemp_limit) begin
            s1_next.fault = FAULT_OVERTEMP;
        end else begin
            ok = 1'b1;
        end

        cnt_inc   = count_reg + 1'b1;
        check_hit = (cnt_inc >= INTERVAL);
        change    = $signed({2'b00, in_temp}) - $signed({2'b00, prev_temp_reg});
        thr       = $signed({2'b00, cfg.slope_threshold});
        if (change < -thr) begin
            new_phase = PH_INHALE;
        end else if (change > thr) begin
            new_phase = PH_EXHALE;
        end else begin
            new_phase = PH_PAUSE;
        end
        phase_eff = check_hit ? new_phase : phase_reg;

        err      = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, in_temp});
        err_diff = $signed({err[ERR_W-1], err}) - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
        abs_err  = err[ERR_W-1] ? 16'(-err) : err[15:0];
        i_prod   = cfg.integ_gain * err[8:0];

        s1_next.vld     = in_vld;
        s1_next.phase   = ok ? phase_eff : phase_reg;
        s1_next.run_pid = ok && (phase_eff != PH_EXHALE);
        s1_next.in_band = !err[ERR_W-1] && (err != '0) && (err[15:0] < BAND_LIMIT);
        s1_next.e_neg   = err[ERR_W-1];
        s1_next.p_mag   = cfg.prop_gain * abs_err;
        s1_next.i_inc   = i_prod[24:4];
        s1_next.d_prod  = $signed({1'b0, cfg.deriv_gain}) * err_diff;

        if (in_vld && ok) begin
            phase_next = phase_eff;
            count_next = check_hit ? '0 : cnt_inc;
            if (check_hit) begin
                prev_temp_next = in_temp;
            end
            prev_err_next = (phase_eff == PH_EXHALE) ? '0 : err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PAUSE;
            count_reg     <= '0;
            prev_temp_reg <= '0;
            prev_err_reg  <= '0;
            s1_reg        <= '0;
        end else if (adv) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            prev_temp_reg <= prev_temp_next;
            prev_err_reg  <= prev_err_next;
            s1_reg        <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bah_integ.sv =====
// Integral stage: signed P term, divided by ten for a negative error, and the clamped integral.
`timescale 1ns / 1ps
`default_nettype none
module bah_integ (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire bah_pkg::cfg_t   cfg,
    input  wire bah_pkg::s1_t    s1,
    output bah_pkg::s2_t    s2
);
    import bah_pkg::*;

    logic [INTEG_W-1:0]  integ_reg, integ_next;
    s2_t                 s2_reg, s2_next;

    logic [63:0]         recip_prod;
    logic [28:0]         p_tenth;
    logic [21:0]         acc_sum;
    logic [21:0]         acc_cap;

    always_comb begin
        recip_prod = s1.p_mag * RECIP_TEN;
        p_tenth    = recip_prod[RECIP_SHIFT +: 29];
        acc_sum    = {5'b0, integ_reg} + {1'b0, s1.i_inc};
        acc_cap    = {5'b0, cfg.pid_ceiling, 7'b0};

        integ_next = integ_reg;
        if (s1.vld && (s1.fault == FAULT_NONE)) begin
            if (!s1.run_pid || !s1.in_band) begin
                integ_next = '0;
            end else if (acc_sum > acc_cap) begin
                integ_next = acc_cap[INTEG_W-1:0];
            end else begin
                integ_next = acc_sum[INTEG_W-1:0];
            end
        end

        s2_next.vld     = s1.vld;
        s2_next.fault   = s1.fault;
        s2_next.phase   = s1.phase;
        s2_next.run_pid = s1.run_pid;
        s2_next.p_term  = s1.e_neg ? -$signed({6'b0, p_tenth}) : $signed({3'b0, s1.p_mag});
        s2_next.integ   = integ_next;
        s2_next.d_prod  = s1.d_prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            s2_reg    <= '0;
        end else if (adv) begin
            integ_reg <= integ_next;
            s2_reg    <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bah_output.sv =====
// Output stage: PID sum, ceiling clamp, feedforward and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bah_output (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire bah_pkg::cfg_t                cfg,
    input  wire bah_pkg::s2_t                 s2,
    output logic                              m_valid,
    output logic [bah_pkg::DUTY_W-1:0]        m_duty,
    output logic [1:0]                        m_breath_phase,
    output logic [1:0]                        m_fault
);
    import bah_pkg::*;

    localparam int SUM_W = 37;

    logic                 valid_reg;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    phase_t               phase_reg;
    fault_t               fault_reg;

    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-13:0]        sum_shift;
    logic [DUTY_W-1:0]        pid;
    logic [DUTY_W:0]          total;

    always_comb begin
        sum = SUM_W'(s2.p_term) + $signed({16'b0, s2.integ, 4'b0}) + SUM_W'(s2.d_prod);
        sum_shift = sum[SUM_W-1:12];
        if (sum[SUM_W-1]) begin
            pid = '0;
        end else if (sum_shift > {15'b0, cfg.pid_ceiling}) begin
            pid = cfg.pid_ceiling;
        end else begin
            pid = sum_shift[DUTY_W-1:0];
        end

        if (s2.phase == PH_INHALE) begin
            total = {1'b0, cfg.feedforward_duty} + {1'b0, pid};
        end else begin
            total = {1'b0, pid};
        end

        if (!s2.run_pid) begin
            duty_next = '0;
        end else if (total > DUTY_MAX) begin
            duty_next = DUTY_MAX[DUTY_W-1:0];
        end else begin
            duty_next = total[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= s2.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            duty_reg  <= duty_next;
            phase_reg <= s2.phase;
            fault_reg <= s2.fault;
        end
    end

    assign m_valid        = valid_reg;
    assign m_duty         = duty_reg;
    assign m_breath_phase = phase_reg;
    assign m_fault        = fault_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/breath_aware_heater_pid_unit.sv =====
// Top level of the breath-aware heater PID unit with feedforward.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one control tick per beat and returns one result beat per tick:
// duty, breath phase and fault code. It accepts a new beat in every clock while
// the result is not stalled, and each beat passes in order through the input
// register, product stage, integral stage and result register. The four stages move
// together, so a result beat that is not taken holds the whole pipeline and input
// ready drops in the same cycle. The breath phase and previous error are tracked in
// the product stage and the integral in the integral stage, so back-to-back ticks
// see the state left by the tick before them. Registers are written through the
// plain write port and should be changed only while no tick is in flight.
module breath_aware_heater_pid_unit #(
    parameter int CHECK_INTERVAL = bah_pkg::CHECK_INTERVAL_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bah_pkg::TEMP_W-1:0]      s_temperature,
    input  wire logic [bah_pkg::TEMP_W-1:0]      s_sensor_level,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bah_pkg::DUTY_W-1:0]           m_duty,
    output logic [1:0]                           m_breath_phase,
    output logic [1:0]                           m_fault,
    input  wire logic                            cfg_we,
    input  wire logic [bah_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bah_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bah_pkg::*;

    logic               adv;
    logic               in_vld_reg;
    logic [TEMP_W-1:0]  in_temp_reg;
    logic [TEMP_W-1:0]  in_level_reg;
    cfg_t               cfg;
    s1_t                s1;
    s2_t                s2;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_temp_reg  <= s_temperature;
            in_level_reg <= s_sensor_level;
        end
    end

    bah_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bah_front #(
        .CHECK_INTERVAL (CHECK_INTERVAL)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (in_vld_reg),
        .in_temp  (in_temp_reg),
        .in_level (in_level_reg),
        .cfg      (cfg),
        .s1       (s1)
    );

    bah_integ u_integ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg),
        .s1      (s1),
        .s2      (s2)
    );

    bah_output u_output (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adv            (adv),
        .cfg            (cfg),
        .s2             (s2),
        .m_valid        (m_valid),
        .m_duty         (m_duty),
        .m_breath_phase (m_breath_phase),
        .m_fault        (m_fault)
    );

    // A faulted tick or an exhale tick never drives the heater.
    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_fault != FAULT_NONE)) |-> (m_duty == '0))
        else $error("duty nonzero on a faulted beat");

    a_exhale_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_breath_phase == PH_EXHALE)) |-> (m_duty == '0))
        else $error("duty nonzero during exhale");

    a_duty_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_duty} <= DUTY_MAX))
        else $error("duty above full scale");

    // A stalled result must not let a new input beat in.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

endmodule
`default_nettype wire
